// ----- rtl/core/kmng_pkg.sv -----
// Shared types and constants of the key event to MIDI note generator.
// Used by the channel interfaces and by every kmng module.
`default_nettype none

package kmng_pkg;

   // Field widths of the request and response words
   localparam int KEY_W  = 9;
   localparam int SEMI_W = 5;
   localparam int OCT_W  = 4;
   localparam int NOTE_W = 7;
   localparam int VEL_W  = 7;

   // Held-note table depth
   localparam int KEY_IDS_DEFAULT = 512;

   // Register port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // Register indexes (paddr[2])
   localparam logic REG_ENABLE       = 1'b0;
   localparam logic REG_START_OCTAVE = 1'b1;

   // Register reset values
   localparam logic             ENABLE_RST       = 1'b1;
   localparam logic [OCT_W-1:0] START_OCTAVE_RST = 4'd5;

   // Note arithmetic
   localparam logic [OCT_W-1:0]  MAX_OCTAVE    = 4'd9;
   localparam logic [NOTE_W:0]   NOTE_MAX      = 8'd127;
   localparam logic [VEL_W-1:0]  VELOCITY_FULL = 7'd127;

   // Operation codes
   localparam logic OP_RELEASE = 1'b0;
   localparam logic OP_PRESS   = 1'b1;

   typedef enum logic [1:0] {
      KIND_UNMAPPED = 2'd0,
      KIND_NOTE     = 2'd1,
      KIND_OCT_DOWN = 2'd2,
      KIND_OCT_UP   = 2'd3
   } kind_type;

   // Configuration handed from the register block to the engine
   typedef struct packed {
      logic             enable;
      logic [OCT_W-1:0] start_octave;
      logic             oct_load;
   } cfg_type;

   // One entry of the held-note table
   typedef struct packed {
      logic              valid;
      logic [NOTE_W-1:0] note;
   } entry_type;

   // Table write request from the engine
   typedef struct packed {
      logic             we;
      logic [KEY_W-1:0] key;
      entry_type        entry;
   } tbl_wr_type;

   // Clamp an octave value to the top octave
   function automatic logic [OCT_W-1:0] clamp_octave(input logic [OCT_W-1:0] v);
      clamp_octave = (v > MAX_OCTAVE) ? MAX_OCTAVE : v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kmng_req_if.sv -----
// Request channel: one classified key event word per handshake.
// Depends on kmng_pkg for field widths.
`default_nettype none

interface kmng_req_if
   import kmng_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KEY_W-1:0]  key_id;
   logic              operation;
   logic [1:0]        key_kind;
   logic [SEMI_W-1:0] semitone;

   modport source (output valid, key_id, operation, key_kind, semitone, input ready);
   modport sink   (input valid, key_id, operation, key_kind, semitone, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/kmng_rsp_if.sv -----
// Response channel: one MIDI note-on or note-off word per handshake.
// Depends on kmng_pkg for field widths.
`default_nettype none

interface kmng_rsp_if
   import kmng_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              note_on;
   logic [NOTE_W-1:0] note_number;
   logic [VEL_W-1:0]  velocity;

   modport source (output valid, note_on, note_number, velocity, input ready);
   modport sink   (input valid, note_on, note_number, velocity, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/key_event_midi_note_gen_top.sv -----
// Each accepted word is held in the event register, where its note is decided,
// and its response word is then held in the response register behind rsp.valid.
// Throughput: one event word per cycle while the response side takes words;
// the held-note table (one write and one read port) is touched once per event.
// Reset: synchronous; after it a clearing pass sweeps every entry of the
// held-note table with req.ready low. Register writes are taken at all times.
`default_nettype none

module key_event_midi_note_gen_top
   import kmng_pkg::*;
#(
   parameter int KEY_IDS = KEY_IDS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   kmng_req_if.sink               req,
   kmng_rsp_if.source             rsp,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cfg_type    cfg;
   logic       tbl_busy;
   logic       tbl_rd_en;
   entry_type  tbl_entry;
   tbl_wr_type tbl_wr;

   // Register block
   kmng_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Held-note table
   kmng_table #(
      .KEY_IDS (KEY_IDS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (tbl_rd_en),
      .rd_key   (req.key_id),
      .wr       (tbl_wr),
      .rd_entry (tbl_entry),
      .busy     (tbl_busy)
   );

   // Note engine
   kmng_engine #(
      .KEY_IDS (KEY_IDS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .cfg       (cfg),
      .tbl_busy  (tbl_busy),
      .tbl_entry (tbl_entry),
      .tbl_rd_en (tbl_rd_en),
      .tbl_wr    (tbl_wr)
   );

endmodule

`default_nettype wire

// ----- rtl/core/kmng_csr.sv -----
// Register block: enable and start_octave behind an APB-style write/read port.
// Depends on kmng_pkg.
`default_nettype none

module kmng_csr
   import kmng_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic             enable_ff, enable_in;
   logic [OCT_W-1:0] start_octave_ff, start_octave_in;
   logic             wr_stb;
   logic             oct_load;

   assign pready = 1'b1;
   assign wr_stb = psel && penable && pwrite;

   // Decode writes
   always_comb begin
      enable_in       = enable_ff;
      start_octave_in = start_octave_ff;
      oct_load        = 1'b0;
      if (wr_stb) begin
         unique case (paddr[2])
            REG_ENABLE: begin
               enable_in = pwdata[0];
            end
            REG_START_OCTAVE: begin
               start_octave_in = pwdata[OCT_W-1:0];
               oct_load        = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= ENABLE_RST;
         start_octave_ff <= START_OCTAVE_RST;
      end else begin
         enable_ff       <= enable_in;
         start_octave_ff <= start_octave_in;
      end
   end

   // Read back
   always_comb begin
      unique case (paddr[2])
         REG_ENABLE:       prdata = DATA_W'(enable_ff);
         REG_START_OCTAVE: prdata = DATA_W'(start_octave_ff);
         default:          prdata = '0;
      endcase
   end

   assign cfg.enable       = enable_ff;
   assign cfg.start_octave = start_octave_in;
   assign cfg.oct_load     = oct_load;

endmodule

`default_nettype wire

// ----- rtl/core/kmng_table.sv -----
// Held-note table: one memory of valid/note entries with a clearing pass
// after reset and write-to-read forwarding. Depends on kmng_pkg.
`default_nettype none

module kmng_table
   import kmng_pkg::*;
#(
   parameter int KEY_IDS = KEY_IDS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rd_en,
   input  wire logic [KEY_W-1:0] rd_key,
   input  wire tbl_wr_type       wr,
   output entry_type             rd_entry,
   output logic                  busy
);

   localparam int AW = $clog2(KEY_IDS);
   localparam int CW = $clog2(KEY_IDS + 1);
   localparam int EW = (AW > KEY_W) ? AW : KEY_W;

   entry_type         mem [KEY_IDS];
   entry_type         rd_data_ff;
   entry_type         fwd_entry_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   logic              clr_busy_ff, clr_busy_in;
   logic [CW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [EW-1:0]     rd_key_ext, wr_key_ext;
   logic [AW-1:0]     rd_addr, wr_addr;

   assign rd_key_ext = EW'(rd_key);
   assign wr_key_ext = EW'(wr.key);
   assign rd_addr    = rd_key_ext[AW-1:0];
   assign wr_addr    = wr_key_ext[AW-1:0];

   // Advance the clearing pass, one entry a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CW'(KEY_IDS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff[AW-1:0]] <= '0;
      end else if (wr.we) begin
         mem[wr_addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Catch a write to the same key landing at the read edge
   assign fwd_hit_in = wr.we && (wr.key == rd_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_entry_ff <= wr.entry;
      end
   end

   assign rd_entry = fwd_hit_ff ? fwd_entry_ff : rd_data_ff;
   assign busy     = clr_busy_ff;

   // No table traffic while the clearing pass runs
   assert property (@(posedge clock) disable iff (reset) clr_busy_ff |-> !rd_en && !wr.we)
      else $error("table access during clearing pass");

   // Clear count stays inside the table while clearing
   assert property (@(posedge clock) disable iff (reset)
                    clr_busy_ff |-> clr_cnt_ff < CW'(KEY_IDS))
      else $error("clear count out of range");

   // Once finished, the clearing pass does not restart
   assert property (@(posedge clock) disable iff (reset) !clr_busy_ff |=> !clr_busy_ff)
      else $error("clearing pass restarted");

endmodule

`default_nettype wire

// ----- rtl/core/kmng_engine.sv -----
// Note engine: event register, octave register, note decision and the
// response register. Depends on kmng_pkg and the channel interfaces.
`default_nettype none

module kmng_engine
   import kmng_pkg::*;
#(
   parameter int KEY_IDS = KEY_IDS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   kmng_req_if.sink        req,
   kmng_rsp_if.source      rsp,
   input  wire cfg_type    cfg,
   input  wire logic       tbl_busy,
   input  wire entry_type  tbl_entry,
   output logic            tbl_rd_en,
   output tbl_wr_type      tbl_wr
);

   localparam int AW = $clog2(KEY_IDS);
   localparam int EW = (AW > KEY_W) ? AW : KEY_W;

   // Event register
   logic              s1_valid_ff, s1_valid_in;
   logic [KEY_W-1:0]  s1_key_ff;
   logic              s1_op_ff;
   kind_type          s1_kind_ff;
   logic [SEMI_W-1:0] s1_semi_ff;

   logic [OCT_W-1:0]  octave_ff, octave_in;

   // Response register
   logic              out_valid_ff, out_valid_in;
   logic              out_note_on_ff;
   logic [NOTE_W-1:0] out_note_ff;

   logic              accept;
   logic              s1_fire;
   logic              act;
   logic              in_table;
   logic [NOTE_W:0]   note_sum;
   logic              has_result;
   logic              res_on;
   logic [NOTE_W-1:0] res_note;
   logic [EW-1:0]     key_ext;

   // Event register drains when the response register is free or being taken
   assign s1_fire   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !tbl_busy && (!s1_valid_ff || s1_fire);
   assign accept    = req.valid && req.ready;
   assign tbl_rd_en = accept;
   assign act       = s1_fire && cfg.enable;

   assign key_ext  = EW'(s1_key_ff);
   assign in_table = ({1'b0, key_ext} < (EW + 1)'(KEY_IDS));

   // semitone + 12 * octave
   assign note_sum = (NOTE_W + 1)'({octave_ff, 3'b000}) + (NOTE_W + 1)'({octave_ff, 2'b00})
                   + (NOTE_W + 1)'(s1_semi_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_key_ff  <= req.key_id;
         s1_op_ff   <= req.operation;
         s1_kind_ff <= kind_type'(req.key_kind);
         s1_semi_ff <= req.semitone;
      end
   end

   // Decide the result, the table update and the new octave
   always_comb begin
      has_result   = 1'b0;
      res_on       = 1'b0;
      res_note     = note_sum[NOTE_W-1:0];
      octave_in    = octave_ff;
      tbl_wr.we    = 1'b0;
      tbl_wr.key   = s1_key_ff;
      tbl_wr.entry = '{valid: 1'b1, note: note_sum[NOTE_W-1:0]};
      if (act) begin
         if (s1_op_ff == OP_PRESS) begin
            unique case (s1_kind_ff)
               KIND_OCT_DOWN: begin
                  if (octave_ff != '0) begin
                     octave_in = octave_ff - 1'b1;
                  end
               end
               KIND_OCT_UP: begin
                  if (octave_ff < MAX_OCTAVE) begin
                     octave_in = octave_ff + 1'b1;
                  end
               end
               KIND_NOTE: begin
                  if (in_table && note_sum <= NOTE_MAX) begin
                     has_result = 1'b1;
                     res_on     = 1'b1;
                     tbl_wr.we  = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end else if (in_table && tbl_entry.valid) begin
            // Release of a held key: send note-off and drop the entry
            has_result   = 1'b1;
            res_note     = tbl_entry.note;
            tbl_wr.we    = 1'b1;
            tbl_wr.entry = '{valid: 1'b0, note: tbl_entry.note};
         end
      end
      if (cfg.oct_load) begin
         octave_in = clamp_octave(cfg.start_octave);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff <= clamp_octave(START_OCTAVE_RST);
      end else begin
         octave_ff <= octave_in;
      end
   end

   // Response register: load on fire, drop once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_fire) begin
         out_valid_in = has_result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && has_result) begin
         out_note_on_ff <= res_on;
         out_note_ff    <= res_note;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.note_on     = out_note_on_ff;
   assign rsp.note_number = out_note_ff;
   assign rsp.velocity    = VELOCITY_FULL;

   // Octave never leaves 0..9
   assert property (@(posedge clock) disable iff (reset) octave_ff <= MAX_OCTAVE)
      else $error("octave above nine");

   // A held event is not lost while the response side stalls
   assert property (@(posedge clock) disable iff (reset)
                    s1_valid_ff && !s1_fire |=> s1_valid_ff)
      else $error("stalled event dropped");

   // A release that finds a held note produces a note-off word
   assert property (@(posedge clock) disable iff (reset)
                    act && s1_op_ff == OP_RELEASE && has_result
                    |=> out_valid_ff && !out_note_on_ff)
      else $error("release did not produce note-off");

   // A table write only comes from a fired, enabled event
   assert property (@(posedge clock) disable iff (reset) tbl_wr.we |-> act)
      else $error("table write without event");

endmodule

`default_nettype wire
